// ===== rtl/core/rpss_pkg.sv =====
// Shared types and constants for the region page-size splitter.
package rpss_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LEFT_W     = 33;
  localparam int unsigned LOG2_W     = 5;
  localparam int unsigned RIGHTS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MASK     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAGE_LOG2 = 1'b1;

  localparam logic [WORD_W-1:0] SIZE_MASK_RST     = 32'h0040_1000;
  localparam logic [LOG2_W-1:0] MIN_PAGE_LOG2_RST = 5'd12;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_NEXT = 1'b1;

  // Control side of the prepared item held between the two stages.
  typedef struct packed {
    logic                valid;
    logic                load;
    logic [RIGHTS_W-1:0] rights;
  } rpss_item_ctl_t;

  // Index of the highest set bit; zero when no bit is set.
  function automatic logic [LOG2_W-1:0] rpss_top_bit(input logic [WORD_W-1:0] vec);
    logic [LOG2_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (vec[i]) begin
        idx = LOG2_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/rpss_load_prep.sv =====
// Input stage: rounds a loaded region to the minimum page and registers the item.
module rpss_load_prep
  import rpss_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LOG2_W-1:0]    min_page_log2,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [WORD_W-1:0]    in_virt_start,
  input  logic [WORD_W-1:0]    in_phys_start,
  input  logic [WORD_W-1:0]    in_length,
  input  logic [RIGHTS_W-1:0]  in_access_rights,
  input  logic                 drain,
  output rpss_item_ctl_t       item_ctl,
  output logic [ADDR_BITS-1:0] item_virt,
  output logic [ADDR_BITS-1:0] item_phys,
  output logic [LEFT_W-1:0]    item_left
);

  rpss_item_ctl_t         ctl_r;
  logic [ADDR_BITS-1:0]   virt_r, virt_nxt;
  logic [ADDR_BITS-1:0]   phys_r, phys_nxt;
  logic [LEFT_W-1:0]      left_r, left_nxt;

  logic [WORD_W-1:0]           min_mask;
  logic [WORD_W-1:0]           virt_w, phys_w;
  logic [WORD_W-1:0]           start_w, pstart_w;
  logic [LEFT_W:0]             end_sum, end_up;
  logic [LEFT_W:0]             span;
  logic [ADDR_BITS+WORD_W-1:0] virt_ab_ext, phys_ab_ext;
  logic [ADDR_BITS+WORD_W-1:0] virt_w_ext, phys_w_ext;
  logic [ADDR_BITS+WORD_W-1:0] start_ext, pstart_ext;
  logic                        take;

  assign in_stall = ctl_r.valid & ~drain;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    min_mask = ~({WORD_W{1'b1}} << min_page_log2);

    // Addresses wrap at the address width before any rounding is applied.
    virt_ab_ext = {{ADDR_BITS{1'b0}}, in_virt_start};
    phys_ab_ext = {{ADDR_BITS{1'b0}}, in_phys_start};
    virt_w_ext  = {{WORD_W{1'b0}}, virt_ab_ext[ADDR_BITS-1:0]};
    phys_w_ext  = {{WORD_W{1'b0}}, phys_ab_ext[ADDR_BITS-1:0]};
    virt_w      = virt_w_ext[WORD_W-1:0];
    phys_w      = phys_w_ext[WORD_W-1:0];

    start_w  = virt_w & ~min_mask;
    pstart_w = phys_w & ~min_mask;

    // The region end is taken without wrapping, so the span needs the extra bits.
    end_sum = {2'b00, virt_w} + {2'b00, in_length} + {2'b00, min_mask};
    end_up  = end_sum & ~{2'b00, min_mask};
    span    = end_up - {2'b00, start_w};

    start_ext  = {{ADDR_BITS{1'b0}}, start_w};
    pstart_ext = {{ADDR_BITS{1'b0}}, pstart_w};
    virt_nxt   = start_ext[ADDR_BITS-1:0];
    phys_nxt   = pstart_ext[ADDR_BITS-1:0];
    left_nxt   = span[LEFT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (!in_stall) begin
      ctl_r.valid  <= in_valid;
      ctl_r.load   <= (in_kind == KIND_LOAD);
      ctl_r.rights <= in_access_rights;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      virt_r <= virt_nxt;
      phys_r <= phys_nxt;
      left_r <= left_nxt;
    end
  end

  assign item_ctl  = ctl_r;
  assign item_virt = virt_r;
  assign item_phys = phys_r;
  assign item_left = left_r;

endmodule

// ===== rtl/core/rpss_chunk_step.sv =====
// Region state, page-size choice and the result register.
module rpss_chunk_step
  import rpss_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WORD_W-1:0]    size_mask,
  input  rpss_item_ctl_t       item_ctl,
  input  logic [ADDR_BITS-1:0] item_virt,
  input  logic [ADDR_BITS-1:0] item_phys,
  input  logic [LEFT_W-1:0]    item_left,
  output logic                 drain,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_chunk_virt,
  output logic [WORD_W-1:0]    out_chunk_phys,
  output logic [LOG2_W-1:0]    out_chunk_log2,
  output logic [RIGHTS_W-1:0]  out_chunk_rights,
  output logic                 out_is_last,
  output logic                 out_no_fit_error
);

  logic [ADDR_BITS-1:0] cur_virt_r, cur_virt_nxt;
  logic [ADDR_BITS-1:0] cur_phys_r, cur_phys_nxt;
  logic [LEFT_W-1:0]    left_r, left_nxt;
  logic [RIGHTS_W-1:0]  rights_r, rights_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    virt_o_r, virt_o_nxt;
  logic [WORD_W-1:0]    phys_o_r, phys_o_nxt;
  logic [LOG2_W-1:0]    log2_o_r, log2_o_nxt;
  logic [RIGHTS_W-1:0]  rights_o_r, rights_o_nxt;
  logic                 last_o_r, last_o_nxt;
  logic                 err_o_r, err_o_nxt;

  logic [ADDR_BITS-1:0]        src_virt, src_phys;
  logic [LEFT_W-1:0]           src_left;
  logic [RIGHTS_W-1:0]         src_rights;
  logic [ADDR_BITS+WORD_W-1:0] virt_ext, phys_ext, size_ext;
  logic [WORD_W-1:0]           virt_w, phys_w, addr_or;
  logic [WORD_W-1:0]           fits, aligned, cand;
  logic                        found;
  logic [LOG2_W-1:0]           pick;
  logic [WORD_W-1:0]           pg_bytes;
  logic [LEFT_W-1:0]           left_after;
  logic [ADDR_BITS-1:0]        size_ab;
  logic                        out_free;

  assign out_free = ~out_valid_r | ~out_stall;
  assign drain    = item_ctl.valid & out_free;

  always_comb begin
    // A load item replaces whatever region was active.
    src_virt   = item_ctl.load ? item_virt : cur_virt_r;
    src_phys   = item_ctl.load ? item_phys : cur_phys_r;
    src_left   = item_ctl.load ? item_left : left_r;
    src_rights = item_ctl.load ? item_ctl.rights : rights_r;

    virt_ext = {{WORD_W{1'b0}}, src_virt};
    phys_ext = {{WORD_W{1'b0}}, src_phys};
    virt_w   = virt_ext[WORD_W-1:0];
    phys_w   = phys_ext[WORD_W-1:0];
    addr_or  = virt_w | phys_w;

    // A size fits when a bit at or above its position is set in the byte count,
    // and both addresses are aligned when no bit below it is set.
    for (int n = 0; n < WORD_W; n++) begin
      fits[n]    = |(src_left >> n);
      aligned[n] = ~|(addr_or & ~({WORD_W{1'b1}} << n));
    end
    cand  = size_mask & fits & aligned;
    found = |cand;
    pick  = rpss_top_bit(cand);

    pg_bytes   = WORD_W'(1) << pick;
    left_after = src_left - {1'b0, pg_bytes};
    size_ext   = {{ADDR_BITS{1'b0}}, pg_bytes};
    size_ab    = size_ext[ADDR_BITS-1:0];

    cur_virt_nxt = src_virt;
    cur_phys_nxt = src_phys;
    left_nxt     = '0;
    rights_nxt   = src_rights;
    if (found) begin
      cur_virt_nxt = src_virt + size_ab;
      cur_phys_nxt = src_phys + size_ab;
      left_nxt     = left_after;
    end

    virt_o_nxt   = virt_w;
    phys_o_nxt   = phys_w;
    rights_o_nxt = src_rights;
    log2_o_nxt   = found ? pick : '0;
    err_o_nxt    = ~found;
    last_o_nxt   = ~found | (left_after == '0);

    // An empty region, or a next request with none active, gives no beat.
    out_valid_nxt = out_valid_r & out_stall;
    if (out_free) begin
      out_valid_nxt = item_ctl.valid & (src_left != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_virt_r  <= '0;
      cur_phys_r  <= '0;
      left_r      <= '0;
      rights_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (drain) begin
        cur_virt_r <= cur_virt_nxt;
        cur_phys_r <= cur_phys_nxt;
        left_r     <= left_nxt;
        rights_r   <= rights_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      virt_o_r   <= virt_o_nxt;
      phys_o_r   <= phys_o_nxt;
      log2_o_r   <= log2_o_nxt;
      rights_o_r <= rights_o_nxt;
      last_o_r   <= last_o_nxt;
      err_o_r    <= err_o_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_virt   = virt_o_r;
  assign out_chunk_phys   = phys_o_r;
  assign out_chunk_log2   = log2_o_r;
  assign out_chunk_rights = rights_o_r;
  assign out_is_last      = last_o_r;
  assign out_no_fit_error = err_o_r;

endmodule

// ===== rtl/core/region_page_size_splitter.sv =====
// Top level of the region page-size splitter: configuration registers and the two stages.
//
//   Channel  Direction  Handshake            Payload
//   in_      sink       in_valid/in_stall    kind, virt/phys start, length, rights
//   out_     source     out_valid/out_stall  chunk virt/phys, log2, rights, last, error
//   cfg_     sink       cfg_we               cfg_index, cfg_wdata
//
// One input beat is accepted per cycle unless a held item stalls the input; its
// result, if any, passes through the input register, then the result register.
// The page choice for one chunk is a single pass through the size mask, so the
// region state is updated as each item drains, ready for the following beat.
// Reset is synchronous and empties both stages; no region is active after it.
// A stalled result holds the result register and, through it, the input register.
module region_page_size_splitter
  import rpss_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [WORD_W-1:0]   in_virt_start,
  input  logic [WORD_W-1:0]   in_phys_start,
  input  logic [WORD_W-1:0]   in_length,
  input  logic [RIGHTS_W-1:0] in_access_rights,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   out_chunk_virt,
  output logic [WORD_W-1:0]   out_chunk_phys,
  output logic [LOG2_W-1:0]   out_chunk_log2,
  output logic [RIGHTS_W-1:0] out_chunk_rights,
  output logic                out_is_last,
  output logic                out_no_fit_error
);

  logic [WORD_W-1:0]    size_mask_r;
  logic [LOG2_W-1:0]    min_page_log2_r;

  rpss_item_ctl_t       item_ctl;
  logic [ADDR_BITS-1:0] item_virt, item_phys;
  logic [LEFT_W-1:0]    item_left;
  logic                 drain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_mask_r     <= SIZE_MASK_RST;
      min_page_log2_r <= MIN_PAGE_LOG2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_MASK:     size_mask_r     <= cfg_wdata;
        CFG_MIN_PAGE_LOG2: min_page_log2_r <= cfg_wdata[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  rpss_load_prep #(
    .ADDR_BITS (ADDR_BITS)
  ) u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .min_page_log2    (min_page_log2_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_virt_start    (in_virt_start),
    .in_phys_start    (in_phys_start),
    .in_length        (in_length),
    .in_access_rights (in_access_rights),
    .drain            (drain),
    .item_ctl         (item_ctl),
    .item_virt        (item_virt),
    .item_phys        (item_phys),
    .item_left        (item_left)
  );

  rpss_chunk_step #(
    .ADDR_BITS (ADDR_BITS)
  ) u_step (
    .clk              (clk),
    .rst_n            (rst_n),
    .size_mask        (size_mask_r),
    .item_ctl         (item_ctl),
    .item_virt        (item_virt),
    .item_phys        (item_phys),
    .item_left        (item_left),
    .drain            (drain),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chunk_virt   (out_chunk_virt),
    .out_chunk_phys   (out_chunk_phys),
    .out_chunk_log2   (out_chunk_log2),
    .out_chunk_rights (out_chunk_rights),
    .out_is_last      (out_is_last),
    .out_no_fit_error (out_no_fit_error)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the region page-size splitter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpss_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 94;

  typedef struct {
    logic                pause;
    logic                kind;
    logic [WORD_W-1:0]   virt;
    logic [WORD_W-1:0]   phys;
    logic [WORD_W-1:0]   len;
    logic [RIGHTS_W-1:0] rights;
  } region_cmd_t;

  typedef struct {
    logic [WORD_W-1:0]   virt;
    logic [WORD_W-1:0]   phys;
    logic [LOG2_W-1:0]   log2;
    logic [RIGHTS_W-1:0] rights;
    logic                last;
    logic                err;
  } chunk_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = KIND_NEXT;
  logic [WORD_W-1:0]    in_virt_start = '0;
  logic [WORD_W-1:0]    in_phys_start = '0;
  logic [WORD_W-1:0]    in_length = '0;
  logic [RIGHTS_W-1:0]  in_access_rights = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_chunk_virt;
  logic [WORD_W-1:0]    out_chunk_phys;
  logic [LOG2_W-1:0]    out_chunk_log2;
  logic [RIGHTS_W-1:0]  out_chunk_rights;
  logic                 out_is_last;
  logic                 out_no_fit_error;

  region_cmd_t region_cmds[$];
  chunk_t      pending_chunks[$];

  // Shadow of the configuration and of the region walk.
  logic [WORD_W-1:0]   sizes_mask;
  logic [LOG2_W-1:0]   min_log2;
  logic [WORD_W-1:0]   walk_virt;
  logic [WORD_W-1:0]   walk_phys;
  logic [LEFT_W-1:0]   walk_left;
  logic [RIGHTS_W-1:0] walk_rights;

  logic in_fire = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   queued_items = 0;
  bit   timed_out = 1'b0;

  region_page_size_splitter #(.ADDR_BITS(32)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_virt_start    (in_virt_start),
    .in_phys_start    (in_phys_start),
    .in_length        (in_length),
    .in_access_rights (in_access_rights),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chunk_virt   (out_chunk_virt),
    .out_chunk_phys   (out_chunk_phys),
    .out_chunk_log2   (out_chunk_log2),
    .out_chunk_rights (out_chunk_rights),
    .out_is_last      (out_is_last),
    .out_no_fit_error (out_no_fit_error)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] low_ones(input int k);
    return (k >= 32) ? '1 : WORD_W'((64'd1 << k) - 64'd1);
  endfunction

  // Advances the region walk by one beat and records the chunk it yields, if any.
  function automatic void predict_chunk(input logic kind, input logic [WORD_W-1:0] v,
                                        input logic [WORD_W-1:0] p,
                                        input logic [WORD_W-1:0] len,
                                        input logic [RIGHTS_W-1:0] r);
    logic [63:0] mm;
    logic [63:0] end_up;
    logic [63:0] start;
    logic [63:0] sz;
    int          pick;
    chunk_t      c;
    pick = -1;
    if (kind == KIND_LOAD) begin
      mm = (64'd1 << min_log2) - 64'd1;
      // The end is rounded up on the full sum, so a region may reach past 2^32.
      end_up = ({32'd0, v} + {32'd0, len} + mm) & ~mm;
      start = {32'd0, v} & ~mm;
      walk_left = LEFT_W'(end_up - start);
      walk_virt = v & ~mm[WORD_W-1:0];
      walk_phys = p & ~mm[WORD_W-1:0];
      walk_rights = r;
    end
    if (walk_left == '0) return;
    for (int n = WORD_W - 1; n >= 0; n--) begin
      sz = 64'd1 << n;
      if (pick < 0 && sizes_mask[n] && {31'd0, walk_left} >= sz &&
          ({32'd0, walk_virt} & (sz - 64'd1)) == 64'd0 &&
          ({32'd0, walk_phys} & (sz - 64'd1)) == 64'd0) begin
        pick = n;
      end
    end
    c.virt = walk_virt;
    c.phys = walk_phys;
    c.rights = walk_rights;
    if (pick < 0) begin
      c.log2 = '0;
      c.last = 1'b1;
      c.err = 1'b1;
      walk_left = '0;
    end else begin
      sz = 64'd1 << pick;
      c.log2 = LOG2_W'(pick);
      c.err = 1'b0;
      walk_left = LEFT_W'({31'd0, walk_left} - sz);
      c.last = (walk_left == '0);
      walk_virt = walk_virt + sz[WORD_W-1:0];
      walk_phys = walk_phys + sz[WORD_W-1:0];
    end
    pending_chunks.push_back(c);
  endfunction

  // Input driver: a beat stays on the port until it is taken.
  always @(negedge clk) begin
    region_cmd_t cmd;
    if (rst_n && !(in_valid && !in_fire)) begin
      if (region_cmds.size() != 0 && region_cmds[0].pause) begin
        in_valid <= 1'b0;
        if (pending_chunks.size() == 0) void'(region_cmds.pop_front());
      end else if (region_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd = region_cmds.pop_front();
        in_valid <= 1'b1;
        in_kind <= cmd.kind;
        in_virt_start <= cmd.virt;
        in_phys_start <= cmd.phys;
        in_length <= cmd.len;
        in_access_rights <= cmd.rights;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: tracks accepted beats on both channels and checks every result.
  always @(posedge clk) begin
    chunk_t exp_c;
    bit     moved;
    moved = 1'b0;
    in_fire <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      sizes_mask = SIZE_MASK_RST;
      min_log2 = MIN_PAGE_LOG2_RST;
      walk_virt = '0;
      walk_phys = '0;
      walk_left = '0;
      walk_rights = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SIZE_MASK) sizes_mask = cfg_wdata;
        else if (cfg_index == CFG_MIN_PAGE_LOG2) min_log2 = cfg_wdata[LOG2_W-1:0];
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        predict_chunk(in_kind, in_virt_start, in_phys_start, in_length, in_access_rights);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_chunks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected chunk virt=%h phys=%h log2=%0d", $realtime,
                     out_chunk_virt, out_chunk_phys, out_chunk_log2);
        end else begin
          exp_c = pending_chunks.pop_front();
          if (out_chunk_virt !== exp_c.virt || out_chunk_phys !== exp_c.phys ||
              out_chunk_log2 !== exp_c.log2 || out_chunk_rights !== exp_c.rights ||
              out_is_last !== exp_c.last || out_no_fit_error !== exp_c.err) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: chunk mismatch exp v=%h p=%h l2=%0d r=%0d last=%b err=%b",
                       $realtime, exp_c.virt, exp_c.phys, exp_c.log2, exp_c.rights,
                       exp_c.last, exp_c.err);
              $display("    got v=%h p=%h l2=%0d r=%0d last=%b err=%b",
                       out_chunk_virt, out_chunk_phys, out_chunk_log2, out_chunk_rights,
                       out_is_last, out_no_fit_error);
            end
          end
        end
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  task automatic push_load(input logic [WORD_W-1:0] v, input logic [WORD_W-1:0] p,
                           input logic [WORD_W-1:0] len, input logic [RIGHTS_W-1:0] r);
    region_cmds.push_back('{1'b0, KIND_LOAD, v, p, len, r});
    queued_items++;
  endtask

  // The address fields of a next beat carry noise; the block must ignore them.
  task automatic push_next();
    region_cmds.push_back('{1'b0, KIND_NEXT, $urandom, $urandom, $urandom,
                            RIGHTS_W'($urandom)});
    queued_items++;
  endtask

  task automatic push_pause();
    region_cmds.push_back('{1'b1, KIND_NEXT, '0, '0, '0, '0});
  endtask

  task automatic push_random_region();
    int                sel;
    int                a;
    int                b;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] len;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      push_next();
    end else if (sel < 15) begin
      push_load($urandom, $urandom, $urandom, RIGHTS_W'($urandom));
      repeat ($urandom_range(0, 2)) push_next();
    end else begin
      // Aligned starts let the large page sizes win; some starts are skewed on purpose.
      a = $urandom_range(0, 31);
      v = $urandom & ~low_ones(a);
      p = $urandom & ~low_ones(a);
      if ($urandom_range(0, 3) == 0) v = v | ($urandom & low_ones(a));
      if ($urandom_range(0, 3) == 0) p = p | ($urandom & low_ones(a));
      b = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(0, 24);
      len = $urandom & low_ones(b);
      push_load(v, p, len, RIGHTS_W'($urandom));
      repeat ($urandom_range(0, 7)) push_next();
    end
  endtask

  task automatic wait_drained();
    while (region_cmds.size() != 0 || in_valid || pending_chunks.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Only the low bits of the minimum page register are kept, so the rest carry noise.
  task automatic set_regs(input logic [WORD_W-1:0] sizes, input logic [LOG2_W-1:0] minl);
    wait_drained();
    write_reg(CFG_SIZE_MASK, sizes);
    write_reg(CFG_MIN_PAGE_LOG2, ($urandom & ~low_ones(LOG2_W)) | WORD_W'(minl));
  endtask

  initial begin
    logic [WORD_W-1:0] sizes;
    logic [LOG2_W-1:0] minl;
    bit                mid_pause;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      begin
        // Directed beats on the reset configuration.
        push_next();
        push_load(32'h0, 32'h0, 32'h0, 3'd0);
        push_load(32'h0000_0123, 32'h0000_0456, 32'h0, 3'd1);
        push_next();
        push_load(32'h0040_0000, 32'h0080_0000, 32'h0080_1000, 3'd7);
        repeat (4) push_next();
        push_load(32'h0040_0000, 32'h0040_1000, 32'h0040_0000, 3'd2);
        push_next();
        push_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd5);
        repeat (2) push_next();
        // With no size supported every region is dropped with an error.
        set_regs(32'h0, 5'd12);
        push_load(32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 3'd3);
        push_next();
        // Byte-sized pages only.
        set_regs(32'h1, 5'd0);
        push_load(32'h3, 32'h5, 32'h2, 3'd4);
        push_next();
        set_regs(32'hFFFF_FFFF, 5'd31);
        push_load(32'h0, 32'h0, 32'h1, 3'd6);
        push_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'd1);
        repeat (3) push_next();
        set_regs(32'hFFFF_FFFF, 5'd0);
        push_load(32'h0, 32'h0, 32'hFFFF_FFFF, 3'd7);
        push_next();

        for (int ph = 0; ph < 8; ph++) begin
          unique case (ph)
            0: begin sizes = SIZE_MASK_RST; minl = MIN_PAGE_LOG2_RST; end
            1: begin sizes = '1; minl = 5'd0; end
            2: begin sizes = $urandom; minl = LOG2_W'($urandom_range(0, 31)); end
            3: begin sizes = '0; minl = LOG2_W'($urandom_range(0, 31)); end
            4: begin sizes = 32'h8000_0001; minl = 5'd31; end
            5: begin sizes = $urandom | 32'h0000_1000; minl = 5'd12; end
            6: begin sizes = $urandom & $urandom; minl = LOG2_W'($urandom_range(0, 12)); end
            default: begin sizes = $urandom | 32'h1; minl = LOG2_W'($urandom_range(0, 31)); end
          endcase
          set_regs(sizes, minl);
          unique case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 63; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 63; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
          endcase
          queued_items = 0;
          mid_pause = 1'b0;
          while (queued_items < PHASE_ITEMS) begin
            if (!mid_pause && queued_items > PHASE_ITEMS / 2) begin
              push_pause();
              mid_pause = 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
              push_pause();
            end
            push_random_region();
          end
        end
        wait_drained();
      end
      begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    disable fork;
    if (!timed_out && mismatches == 0 && pending_chunks.size() == 0)
      $display("PASS region_page_size_splitter");
    else
      $display("FAIL region_page_size_splitter");
    $finish;
  end

endmodule
